/* rtl/sdsce_pkg.sv */
// Shared types, codes and helper functions for the SD card SPI command engine.
// Used by every module of the engine; depends on nothing else.
`default_nettype none

package sdsce_pkg;

    // Field widths
    localparam int unsigned LIMIT_W = 20;
    localparam int unsigned CMD_W   = 6;
    localparam int unsigned ARG_W   = 32;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned EXTRA_W = 3;
    localparam int unsigned R1_W    = 7;
    localparam int unsigned REQ_W   = 2;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned PHASE_W = 3;
    localparam int unsigned BIDX_W  = 3;

    // Stream packing widths
    localparam int unsigned IN_TDATA_W  = 64;
    localparam int unsigned OUT_TDATA_W = 24;

    // Command queue between the front and the back
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
    localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

    // Register reset values
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(100000);

    // Configuration register indexes
    localparam logic CFG_BUSY = 1'b0;
    localparam logic CFG_RESP = 1'b1;

    // Request types carried in the input tuser
    localparam logic [REQ_W-1:0] REQ_CMD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RX   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REL  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;

    // Result kinds carried in the output tuser
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // Completion status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_BUSY_TO = 2'd1;
    localparam logic [STAT_W-1:0] ST_RESP_TO = 2'd2;

    // Sequencer phases
    localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_BUSY  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_RESP  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_EXTRA = 3'd3;

    // Bus constants
    localparam logic [BYTE_W-1:0] BYTE_IDLE  = 8'hFF;
    localparam logic [BYTE_W-1:0] CMD_PREFIX = 8'h40;
    localparam logic [BYTE_W-1:0] CRC_POLY   = 8'h09;

    // One classified request as it sits in the queue
    typedef struct packed {
        logic [REQ_W-1:0]   op;
        logic [CMD_W-1:0]   cmd;
        logic [ARG_W-1:0]   arg;
        logic [BYTE_W-1:0]  crc;
        logic [EXTRA_W-1:0] extra;
        logic               rel;
        logic [BYTE_W-1:0]  rx;
    } t_item;

    // One result leaving the engine
    typedef struct packed {
        logic               kind;
        logic [BYTE_W-1:0]  tx;
        logic               expect_reply;
        logic               chip_select;
        logic [STAT_W-1:0]  status;
        logic [R1_W-1:0]    response;
        logic               last;
    } t_result;

    // Poll limits handed to the back end
    typedef struct packed {
        logic [LIMIT_W-1:0] busy_lim;
        logic [LIMIT_W-1:0] resp_lim;
    } t_cfg;

    // Advance the frame checksum over one byte, most significant bit first.
    function automatic logic [BYTE_W-1:0] crc7_byte(input logic [BYTE_W-1:0] crc_in,
                                                    input logic [BYTE_W-1:0] data);
        logic [BYTE_W-1:0] c;
        logic [BYTE_W-1:0] d;
        c = crc_in;
        d = data;
        for (int j = 0; j < BYTE_W; j++) begin
            c = {c[BYTE_W-2:0], 1'b0};
            if (d[BYTE_W-1] ^ c[BYTE_W-1]) begin
                c = c ^ CRC_POLY;
            end
            d = {d[BYTE_W-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/sd_spi_command_engine_core.sv */
// SD card SPI command engine: every request yields between zero and seven byte
// transfers or completions on the output stream, one per clock unless the output
// stalls. The front end takes a request every cycle while its four-entry queue has
// room; the back end emits all results of a request before it takes the next, so
// the average is set by the output stream and each request's result count (a command
// frame has seven). The user must write the poll limits through the configuration
// channel only while the engine is idle; the block does not enforce this. A zero
// response limit behaves as one. Depends on sdsce_pkg, sdsce_front and sdsce_back.
`default_nettype none

module sd_spi_command_engine_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Configuration writes
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic                              i_cfg_index,
    input  wire logic [sdsce_pkg::LIMIT_W-1:0]     i_cfg_data,
    // Requests
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata: cmd_index, cmd_arg, crc_byte, extra_bytes, release_after, rx_byte, zero fill
    input  wire logic [sdsce_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: req_type
    input  wire logic [sdsce_pkg::REQ_W-1:0]       s_axis_tuser,
    // Results
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // tdata: tx_byte, expect_reply, chip_select, status, response, zero fill
    output logic [sdsce_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // tuser: out_kind
    output logic                                   m_axis_tuser,
    output logic                                   m_axis_tlast
);
    import sdsce_pkg::*;

    logic [LIMIT_W-1:0] r_busy_lim;
    logic [LIMIT_W-1:0] r_resp_lim;
    t_cfg               w_cfg;
    logic               w_q_valid;
    t_item              w_q_item;
    logic               w_q_pop;
    t_result            w_res;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy_lim <= LIMIT_RESET;
            r_resp_lim <= LIMIT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BUSY: r_busy_lim <= i_cfg_data;
                CFG_RESP: r_resp_lim <= i_cfg_data;
            endcase
        end
    end

    assign w_cfg.busy_lim = r_busy_lim;
    assign w_cfg.resp_lim = r_resp_lim;

    sdsce_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_q_valid     (w_q_valid),
        .o_q_item      (w_q_item),
        .i_q_pop       (w_q_pop)
    );

    sdsce_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_q_item),
        .o_q_pop     (w_q_pop),
        .o_res_valid (m_axis_tvalid),
        .o_res       (w_res),
        .i_res_ready (m_axis_tready)
    );

    // Pack the result onto the output stream.
    assign m_axis_tdata = {5'b00000, w_res.response, w_res.status, w_res.chip_select,
                           w_res.expect_reply, w_res.tx};
    assign m_axis_tuser = w_res.kind;
    assign m_axis_tlast = w_res.last;

    // A busy timeout leaves the card selected.
    a_busy_to_keeps_cs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_DONE) && (m_axis_tdata[11:10] == ST_BUSY_TO))
        |-> !m_axis_tdata[9])
        else $error("busy timeout completion reports chip select released");

    // A response timeout always leaves the card deselected.
    a_resp_to_drops_cs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_DONE) && (m_axis_tdata[11:10] == ST_RESP_TO))
        |-> m_axis_tdata[9])
        else $error("response timeout completion reports chip select asserted");

    // A busy limit write lands in the register on the next clock.
    a_cfg_busy_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready && (i_cfg_index == CFG_BUSY))
        |=> (r_busy_lim == $past(i_cfg_data)))
        else $error("busy limit write was not taken");

endmodule

`default_nettype wire

/* rtl/sdsce_front.sv */
// Front end of the SD card SPI command engine: unpacks and classifies requests
// and holds them in a short queue for the back end. Depends on sdsce_pkg.
`default_nettype none

module sdsce_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: cmd_index, cmd_arg, crc_byte, extra_bytes, release_after, rx_byte, zero fill
    input  wire logic [sdsce_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // tuser: req_type
    input  wire logic [sdsce_pkg::REQ_W-1:0]    s_axis_tuser,
    output logic                                o_q_valid,
    output sdsce_pkg::t_item                    o_q_item,
    input  wire logic                           i_q_pop
);
    import sdsce_pkg::*;

    t_item              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]    r_wr_ptr;
    logic [Q_AW-1:0]    r_rd_ptr;
    logic [Q_CW-1:0]    r_count;
    logic [Q_AW-1:0]    n_wr_ptr;
    logic [Q_AW-1:0]    n_rd_ptr;
    logic [Q_CW-1:0]    n_count;
    t_item              w_item;
    logic               w_push;
    logic               w_pop;

    // Unpack the transaction; unused request types are dropped here.
    always_comb begin
        w_item.op    = s_axis_tuser;
        w_item.cmd   = s_axis_tdata[5:0];
        w_item.arg   = s_axis_tdata[37:6];
        w_item.crc   = s_axis_tdata[45:38];
        w_item.extra = s_axis_tdata[48:46];
        w_item.rel   = s_axis_tdata[49];
        w_item.rx    = s_axis_tdata[57:50];
    end

    assign s_axis_tready = (r_count != Q_CW'(Q_DEPTH));
    assign w_push = s_axis_tvalid && s_axis_tready && (s_axis_tuser != REQ_NONE);
    assign o_q_valid = (r_count != '0);
    assign w_pop  = i_q_pop && o_q_valid;
    assign o_q_item = r_mem[r_rd_ptr];

    // Queue pointers and fill count.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

endmodule

`default_nettype wire

/* rtl/sdsce_back.sv */
// Back end of the SD card SPI command engine: the command sequencer, the frame
// and checksum generator and the result register. Depends on sdsce_pkg.
`default_nettype none

module sdsce_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire sdsce_pkg::t_cfg    i_cfg,
    input  wire logic               i_q_valid,
    input  wire sdsce_pkg::t_item   i_q_item,
    output logic                    o_q_pop,
    output logic                    o_res_valid,
    output sdsce_pkg::t_result      o_res,
    input  wire logic               i_res_ready
);
    import sdsce_pkg::*;

    // Sequencer state
    logic [PHASE_W-1:0] r_phase,  n_phase;
    logic               r_cs,     n_cs;
    logic [LIMIT_W-1:0] r_poll,   n_poll;
    logic [CMD_W-1:0]   r_cmd,    n_cmd;
    logic [ARG_W-1:0]   r_arg,    n_arg;
    logic [BYTE_W-1:0]  r_crc,    n_crc;
    logic [EXTRA_W-1:0] r_extra,  n_extra;
    logic               r_rel,    n_rel;
    logic [R1_W-1:0]    r_r1,     n_r1;
    logic [BYTE_W-1:0]  r_acc,    n_acc;

    // Burst of follow-on results
    logic               r_b_act,    n_b_act;
    logic               r_b_frame,  n_b_frame;
    logic [BIDX_W-1:0]  r_b_idx,    n_b_idx;
    logic [STAT_W-1:0]  r_b_status, n_b_status;
    logic [R1_W-1:0]    r_b_resp,   n_b_resp;

    // Result register
    logic               r_ov,  n_ov;
    t_result            r_res, n_res;

    logic               w_free;
    logic               v_em;
    t_result            v_res;
    logic [LIMIT_W-1:0] w_resp_lim;
    logic [BYTE_W-1:0]  w_frame0;
    logic [BYTE_W-1:0]  v_byte;

    assign w_free     = !r_ov || i_res_ready;
    assign w_resp_lim = (i_cfg.resp_lim == '0) ? LIMIT_W'(1) : i_cfg.resp_lim;
    assign w_frame0   = CMD_PREFIX | {2'b00, r_cmd};

    assign o_res_valid = r_ov;
    assign o_res       = r_res;

    // Sequencer: either continue a burst or take the next queued request.
    always_comb begin
        n_phase    = r_phase;
        n_cs       = r_cs;
        n_poll     = r_poll;
        n_cmd      = r_cmd;
        n_arg      = r_arg;
        n_crc      = r_crc;
        n_extra    = r_extra;
        n_rel      = r_rel;
        n_r1       = r_r1;
        n_acc      = r_acc;
        n_b_act    = r_b_act;
        n_b_frame  = r_b_frame;
        n_b_idx    = r_b_idx;
        n_b_status = r_b_status;
        n_b_resp   = r_b_resp;
        o_q_pop    = 1'b0;
        v_em       = 1'b0;
        v_res      = '0;
        v_byte     = '0;

        if (r_b_act) begin
            if (w_free) begin
                v_em              = 1'b1;
                v_res.chip_select = !r_cs;
                n_b_idx           = r_b_idx + 1'b1;
                if (r_b_frame) begin
                    // Argument bytes, then checksum, then the first response poll.
                    unique case (r_b_idx)
                        3'd1:    v_byte = r_arg[31:24];
                        3'd2:    v_byte = r_arg[23:16];
                        3'd3:    v_byte = r_arg[15:8];
                        3'd4:    v_byte = r_arg[7:0];
                        3'd5:    v_byte = (r_crc != '0) ? r_crc : {r_acc[6:0], 1'b1};
                        default: v_byte = BYTE_IDLE;
                    endcase
                    v_res.tx = v_byte;
                    if (r_b_idx <= 3'd4) begin
                        n_acc = crc7_byte(r_acc, v_byte);
                    end
                    if (r_b_idx >= 3'd6) begin
                        v_res.expect_reply = 1'b1;
                        v_res.last         = 1'b1;
                        n_b_act            = 1'b0;
                    end
                end else begin
                    // Completion after the chip select release byte.
                    v_res.kind     = KIND_DONE;
                    v_res.status   = r_b_status;
                    v_res.response = r_b_resp;
                    v_res.last     = 1'b1;
                    n_b_act        = 1'b0;
                end
            end
        end else if (i_q_valid && w_free) begin
            o_q_pop = 1'b1;
            unique case (i_q_item.op)
                REQ_CMD: begin
                    n_cmd   = i_q_item.cmd;
                    n_arg   = i_q_item.arg;
                    n_crc   = i_q_item.crc;
                    n_extra = i_q_item.extra;
                    n_rel   = i_q_item.rel;
                    n_r1    = '0;
                    n_cs    = 1'b1;
                    n_poll  = '0;
                    n_phase = PH_BUSY;
                    v_em               = 1'b1;
                    v_res.tx           = BYTE_IDLE;
                    v_res.expect_reply = 1'b1;
                    v_res.last         = 1'b1;
                end
                REQ_RX: begin
                    unique case (r_phase)
                        PH_BUSY: begin
                            if (i_q_item.rx == BYTE_IDLE) begin
                                // Card ready: start the six-byte frame.
                                v_em      = 1'b1;
                                v_res.tx  = w_frame0;
                                n_acc     = crc7_byte('0, w_frame0);
                                n_b_act   = 1'b1;
                                n_b_frame = 1'b1;
                                n_b_idx   = 3'd1;
                                n_poll    = LIMIT_W'(1);
                                n_phase   = PH_RESP;
                            end else if (r_poll < i_cfg.busy_lim) begin
                                n_poll             = r_poll + 1'b1;
                                v_em               = 1'b1;
                                v_res.tx           = BYTE_IDLE;
                                v_res.expect_reply = 1'b1;
                                v_res.last         = 1'b1;
                            end else begin
                                v_em         = 1'b1;
                                v_res.kind   = KIND_DONE;
                                v_res.status = ST_BUSY_TO;
                                v_res.last   = 1'b1;
                                n_phase      = PH_IDLE;
                            end
                        end
                        PH_RESP: begin
                            if (!i_q_item.rx[7]) begin
                                n_r1 = i_q_item.rx[R1_W-1:0];
                                if (r_extra != '0) begin
                                    n_phase            = PH_EXTRA;
                                    v_em               = 1'b1;
                                    v_res.tx           = BYTE_IDLE;
                                    v_res.expect_reply = 1'b1;
                                    v_res.last         = 1'b1;
                                end else begin
                                    n_phase    = PH_IDLE;
                                    v_em       = 1'b1;
                                    n_b_status = ST_OK;
                                    n_b_resp   = i_q_item.rx[R1_W-1:0];
                                    if (r_rel && r_cs) begin
                                        n_cs      = 1'b0;
                                        v_res.tx  = BYTE_IDLE;
                                        n_b_act   = 1'b1;
                                        n_b_frame = 1'b0;
                                    end else begin
                                        v_res.kind     = KIND_DONE;
                                        v_res.response = i_q_item.rx[R1_W-1:0];
                                        v_res.last     = 1'b1;
                                    end
                                end
                            end else if (r_poll < w_resp_lim) begin
                                n_poll             = r_poll + 1'b1;
                                v_em               = 1'b1;
                                v_res.tx           = BYTE_IDLE;
                                v_res.expect_reply = 1'b1;
                                v_res.last         = 1'b1;
                            end else begin
                                // Response timeout: release the card, then report.
                                n_phase    = PH_IDLE;
                                v_em       = 1'b1;
                                n_b_status = ST_RESP_TO;
                                n_b_resp   = '0;
                                if (r_cs) begin
                                    n_cs      = 1'b0;
                                    v_res.tx  = BYTE_IDLE;
                                    n_b_act   = 1'b1;
                                    n_b_frame = 1'b0;
                                end else begin
                                    v_res.kind   = KIND_DONE;
                                    v_res.status = ST_RESP_TO;
                                    v_res.last   = 1'b1;
                                end
                            end
                        end
                        PH_EXTRA: begin
                            n_extra = r_extra - 1'b1;
                            v_em    = 1'b1;
                            if (n_extra != '0) begin
                                v_res.tx           = BYTE_IDLE;
                                v_res.expect_reply = 1'b1;
                                v_res.last         = 1'b1;
                            end else begin
                                n_phase    = PH_IDLE;
                                n_b_status = ST_OK;
                                n_b_resp   = r_r1;
                                if (r_rel && r_cs) begin
                                    n_cs      = 1'b0;
                                    v_res.tx  = BYTE_IDLE;
                                    n_b_act   = 1'b1;
                                    n_b_frame = 1'b0;
                                end else begin
                                    v_res.kind     = KIND_DONE;
                                    v_res.response = r_r1;
                                    v_res.last     = 1'b1;
                                end
                            end
                        end
                        default: begin
                            // A received byte while idle has no effect.
                        end
                    endcase
                end
                REQ_REL: begin
                    n_phase = PH_IDLE;
                    if (r_cs) begin
                        n_cs       = 1'b0;
                        v_em       = 1'b1;
                        v_res.tx   = BYTE_IDLE;
                        v_res.last = 1'b1;
                    end
                end
                default: begin
                    // Unused request types never reach the queue.
                end
            endcase
            v_res.chip_select = !n_cs;
        end

        // Result register: load on emit, otherwise drain when taken.
        n_ov  = r_ov;
        n_res = r_res;
        if (v_em) begin
            n_ov  = 1'b1;
            n_res = v_res;
        end else if (i_res_ready) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cs    <= 1'b0;
            r_poll  <= '0;
            r_extra <= '0;
            r_rel   <= 1'b0;
            r_r1    <= '0;
            r_b_act <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cs    <= n_cs;
            r_poll  <= n_poll;
            r_extra <= n_extra;
            r_rel   <= n_rel;
            r_r1    <= n_r1;
            r_b_act <= n_b_act;
            r_ov    <= n_ov;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_arg      <= n_arg;
        r_crc      <= n_crc;
        r_acc      <= n_acc;
        r_b_frame  <= n_b_frame;
        r_b_idx    <= n_b_idx;
        r_b_status <= n_b_status;
        r_b_resp   <= n_b_resp;
        r_res      <= n_res;
    end

endmodule

`default_nettype wire

/* sim/sd_spi_command_engine_checker.sv */
`timescale 1ns / 1ps
// Result checker for the SD card SPI command engine: follows the configuration, request
// and result transactions, predicts the engine's results and compares them field by field.
// Depends on sdsce_pkg for the field widths, the codes and the request and result types.

module sd_spi_command_engine_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic                              i_cfg_index,
    input  logic [sdsce_pkg::LIMIT_W-1:0]     i_cfg_data,
    input  logic                              i_req_valid,
    input  logic                              i_req_ready,
    // cmd_index, cmd_arg, crc_byte, extra_bytes, release_after, rx_byte, zero fill
    input  logic [sdsce_pkg::IN_TDATA_W-1:0]  i_req_data,
    // req_type
    input  logic [sdsce_pkg::REQ_W-1:0]       i_req_user,
    input  logic                              i_res_valid,
    input  logic                              i_res_ready,
    // tx_byte, expect_reply, chip_select, status, response, zero fill
    input  logic [sdsce_pkg::OUT_TDATA_W-1:0] i_res_data,
    // out_kind
    input  logic                              i_res_user,
    input  logic                              i_res_last,
    output int                                o_outstanding,
    output int                                o_failures
);
    import sdsce_pkg::*;

    // Poll limits as last written
    logic [LIMIT_W-1:0] busy_limit;
    logic [LIMIT_W-1:0] resp_limit;

    // Predicted sequencer state
    logic [PHASE_W-1:0] eng_phase;
    logic               cs_held;
    logic [LIMIT_W-1:0] polls_done;
    logic [CMD_W-1:0]   held_cmd;
    logic [ARG_W-1:0]   held_arg;
    logic [BYTE_W-1:0]  held_crc;
    logic [EXTRA_W-1:0] extras_left;
    logic               release_due;
    logic [R1_W-1:0]    r1_latched;

    t_result step_results[$];
    t_result expected_results[$];
    t_item   seen_req;
    int      mismatches = 0;
    int      results_seen = 0;

    // CRC7 over the first five frame bytes, returned with the end bit appended.
    function automatic logic [BYTE_W-1:0] frame_crc7(input logic [CMD_W-1:0] cmd,
                                                     input logic [ARG_W-1:0] arg);
        logic [39:0] frame_bits;
        logic [6:0]  crc;
        logic        feedback;
        frame_bits = {2'b01, cmd, arg};
        crc = '0;
        for (int k = 39; k >= 0; k--) begin
            feedback = frame_bits[k] ^ crc[6];
            crc = {crc[5:0], 1'b0} ^ (feedback ? 7'h09 : 7'h00);
        end
        return {crc, 1'b1};
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
        mismatches++;
    endtask

    // Append one result of the current request; chip select is taken as it stands now.
    task automatic queue_result(input logic kind, input logic [BYTE_W-1:0] tx,
                                input logic reply, input logic [STAT_W-1:0] stat,
                                input logic [R1_W-1:0] resp);
        t_result r;
        r.kind         = kind;
        r.tx           = tx;
        r.expect_reply = reply;
        r.chip_select  = ~cs_held;
        r.status       = stat;
        r.response     = resp;
        r.last         = 1'b0;
        step_results.push_back(r);
    endtask

    // Raising chip select always clocks out one idle byte with the line high.
    task automatic drop_chip_select();
        if (cs_held) begin
            cs_held = 1'b0;
            queue_result(KIND_BYTE, BYTE_IDLE, 1'b0, ST_OK, '0);
        end
    endtask

    task automatic finish_command();
        if (release_due) begin
            drop_chip_select();
        end
        queue_result(KIND_DONE, '0, 1'b0, ST_OK, r1_latched);
        eng_phase = PH_IDLE;
    endtask

    // Work out every result that one accepted request causes.
    task automatic predict_engine_step(input t_item req);
        t_result r;
        step_results.delete();
        case (req.op)
            REQ_CMD: begin
                held_cmd    = req.cmd;
                held_arg    = req.arg;
                held_crc    = (req.crc == '0) ? frame_crc7(req.cmd, req.arg) : req.crc;
                extras_left = req.extra;
                release_due = req.rel;
                r1_latched  = '0;
                cs_held     = 1'b1;
                polls_done  = '0;
                eng_phase   = PH_BUSY;
                queue_result(KIND_BYTE, BYTE_IDLE, 1'b1, ST_OK, '0);
            end
            REQ_RX: begin
                if (eng_phase == PH_BUSY) begin
                    if (req.rx == BYTE_IDLE) begin
                        // Card ready: the whole frame goes out, then the first response poll.
                        queue_result(KIND_BYTE, CMD_PREFIX | {2'b00, held_cmd}, 1'b0, ST_OK, '0);
                        queue_result(KIND_BYTE, held_arg[31:24], 1'b0, ST_OK, '0);
                        queue_result(KIND_BYTE, held_arg[23:16], 1'b0, ST_OK, '0);
                        queue_result(KIND_BYTE, held_arg[15:8], 1'b0, ST_OK, '0);
                        queue_result(KIND_BYTE, held_arg[7:0], 1'b0, ST_OK, '0);
                        queue_result(KIND_BYTE, held_crc, 1'b0, ST_OK, '0);
                        queue_result(KIND_BYTE, BYTE_IDLE, 1'b1, ST_OK, '0);
                        polls_done = LIMIT_W'(1);
                        eng_phase  = PH_RESP;
                    end else if (polls_done < busy_limit) begin
                        polls_done++;
                        queue_result(KIND_BYTE, BYTE_IDLE, 1'b1, ST_OK, '0);
                    end else begin
                        // Busy timeout leaves chip select asserted.
                        queue_result(KIND_DONE, '0, 1'b0, ST_BUSY_TO, '0);
                        eng_phase = PH_IDLE;
                    end
                end else if (eng_phase == PH_RESP) begin
                    if (!req.rx[7]) begin
                        r1_latched = req.rx[6:0];
                        if (extras_left != '0) begin
                            eng_phase = PH_EXTRA;
                            queue_result(KIND_BYTE, BYTE_IDLE, 1'b1, ST_OK, '0);
                        end else begin
                            finish_command();
                        end
                    end else if (polls_done < resp_limit) begin
                        polls_done++;
                        queue_result(KIND_BYTE, BYTE_IDLE, 1'b1, ST_OK, '0);
                    end else begin
                        drop_chip_select();
                        queue_result(KIND_DONE, '0, 1'b0, ST_RESP_TO, '0);
                        eng_phase = PH_IDLE;
                    end
                end else if (eng_phase == PH_EXTRA) begin
                    extras_left--;
                    if (extras_left != '0) begin
                        queue_result(KIND_BYTE, BYTE_IDLE, 1'b1, ST_OK, '0);
                    end else begin
                        finish_command();
                    end
                end
            end
            REQ_REL: begin
                eng_phase = PH_IDLE;
                drop_chip_select();
            end
            default: begin
            end
        endcase
        for (int k = 0; k < step_results.size(); k++) begin
            r = step_results[k];
            r.last = (k == step_results.size() - 1);
            expected_results.push_back(r);
        end
    endtask

    // Compare one accepted result with the oldest expectation.
    task automatic check_result();
        t_result want;
        results_seen++;
        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("nothing expected, got kind %0d tdata %h last %0d",
                                      i_res_user, i_res_data, i_res_last));
            return;
        end
        want = expected_results.pop_front();
        if (i_res_user !== want.kind)
            report_mismatch($sformatf("out_kind %0d, expected %0d", i_res_user, want.kind));
        if (i_res_data[7:0] !== want.tx)
            report_mismatch($sformatf("tx_byte %h, expected %h", i_res_data[7:0], want.tx));
        if (i_res_data[8] !== want.expect_reply)
            report_mismatch($sformatf("expect_reply %0d, expected %0d", i_res_data[8],
                                      want.expect_reply));
        if (i_res_data[9] !== want.chip_select)
            report_mismatch($sformatf("chip_select %0d, expected %0d", i_res_data[9],
                                      want.chip_select));
        if (i_res_data[11:10] !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", i_res_data[11:10],
                                      want.status));
        if (i_res_data[18:12] !== want.response)
            report_mismatch($sformatf("response %h, expected %h", i_res_data[18:12],
                                      want.response));
        if (i_res_last !== want.last)
            report_mismatch($sformatf("last %0d, expected %0d", i_res_last, want.last));
    endtask

    // Results are checked before the request of the same edge is predicted, so a
    // result can never be matched against an expectation made at its own edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            busy_limit  = LIMIT_RESET;
            resp_limit  = LIMIT_RESET;
            eng_phase   = PH_IDLE;
            cs_held     = 1'b0;
            polls_done  = '0;
            held_cmd    = '0;
            held_arg    = '0;
            held_crc    = '0;
            extras_left = '0;
            release_due = 1'b0;
            r1_latched  = '0;
            expected_results.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                check_result();
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_BUSY) begin
                    busy_limit = i_cfg_data;
                end else begin
                    resp_limit = i_cfg_data;
                end
            end
            if (i_req_valid && i_req_ready) begin
                seen_req.op    = i_req_user;
                seen_req.cmd   = i_req_data[5:0];
                seen_req.arg   = i_req_data[37:6];
                seen_req.crc   = i_req_data[45:38];
                seen_req.extra = i_req_data[48:46];
                seen_req.rel   = i_req_data[49];
                seen_req.rx    = i_req_data[57:50];
                predict_engine_step(seen_req);
            end
        end
        o_outstanding <= expected_results.size();
        o_failures    <= mismatches;
    end

endmodule

/* sim/sd_spi_command_engine_core_test.sv */
`timescale 1ns / 1ps
// Testbench top for the SD card SPI command engine: clock, reset, request and register
// stimulus, receiver stalls, the watchdog and the verdict.
// Depends on sdsce_pkg, sd_spi_command_engine_core and sd_spi_command_engine_checker.

module sd_spi_command_engine_core_test;
    import sdsce_pkg::*;

    localparam int RESET_CYCLES   = 11;
    localparam int SETTLE_CYCLES  = 24;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic                   i_cfg_index = CFG_BUSY;
    logic [LIMIT_W-1:0]     i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [REQ_W-1:0]       s_axis_tuser = REQ_NONE;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   m_axis_tlast;

    int outstanding;
    int failures;
    int quiet_cycles = 0;
    int steady_left = 0;
    int ready_hold = 0;
    int busy_lim_now = int'(LIMIT_RESET);
    int resp_lim_now = int'(LIMIT_RESET);

    sd_spi_command_engine_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    sd_spi_command_engine_checker result_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_req_valid   (s_axis_tvalid),
        .i_req_ready   (s_axis_tready),
        .i_req_data    (s_axis_tdata),
        .i_req_user    (s_axis_tuser),
        .i_res_valid   (m_axis_tvalid),
        .i_res_ready   (m_axis_tready),
        .i_res_data    (m_axis_tdata),
        .i_res_user    (m_axis_tuser),
        .i_res_last    (m_axis_tlast),
        .o_outstanding (outstanding),
        .o_failures    (failures)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Receiver: steady stretches, short stalls and the odd long one.
    always @(negedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: begin
                    m_axis_tready <= 1'b1;
                    ready_hold    <= $urandom_range(0, 30);
                end
                19: begin
                    m_axis_tready <= 1'b0;
                    ready_hold    <= $urandom_range(10, 40);
                end
                default: begin
                    m_axis_tready <= 1'b0;
                    ready_hold    <= $urandom_range(0, 3);
                end
            endcase
        end
    end

    // Watchdog: ends the run when no transaction of any kind happens for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Sender gap: mostly none or short, now and then long, with runs of no gaps.
    function automatic int pick_gap();
        int roll;
        if (steady_left > 0) begin
            steady_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            steady_left = $urandom_range(5, 20);
            return 0;
        end
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // A request with every field random; extra bytes stay between zero and four.
    function automatic t_item filler(input logic [REQ_W-1:0] op);
        t_item it;
        it.op    = op;
        it.cmd   = CMD_W'($urandom_range(0, 63));
        it.arg   = $urandom;
        it.crc   = BYTE_W'($urandom_range(0, 255));
        it.extra = EXTRA_W'($urandom_range(0, 4));
        it.rel   = 1'($urandom_range(0, 1));
        it.rx    = BYTE_W'($urandom_range(0, 255));
        return it;
    endfunction

    function automatic t_item card_byte(input logic [BYTE_W-1:0] rx);
        t_item it;
        it    = filler(REQ_RX);
        it.rx = rx;
        return it;
    endfunction

    function automatic t_item command_item(input logic [CMD_W-1:0] cmd,
                                           input logic [ARG_W-1:0] arg,
                                           input logic [BYTE_W-1:0] crc,
                                           input logic [EXTRA_W-1:0] extra,
                                           input logic rel);
        t_item it;
        it       = filler(REQ_CMD);
        it.cmd   = cmd;
        it.arg   = arg;
        it.crc   = crc;
        it.extra = extra;
        it.rel   = rel;
        return it;
    endfunction

    // Entered and left at a falling edge; valid is dropped once the transaction is done.
    task automatic send_request(input t_item it);
        int gap;
        gap = pick_gap();
        repeat (gap) @(negedge i_clk);
        s_axis_tdata  = {6'b0, it.rx, it.rel, it.extra, it.crc, it.arg, it.cmd};
        s_axis_tuser  = it.op;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic write_config(input logic idx, input logic [LIMIT_W-1:0] value);
        i_cfg_index = idx;
        i_cfg_data  = value;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        if (idx == CFG_BUSY) begin
            busy_lim_now = int'(value);
        end else begin
            resp_lim_now = int'(value);
        end
    endtask

    // Wait for every expected result, then let requests without results drain too.
    task automatic wait_for_drain();
        while (outstanding != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Sends a request while the sequence still has budget left.
    task automatic feed_item(input t_item it, inout int budget, inout int sent);
        if (budget > 0) begin
            send_request(it);
            budget--;
            sent++;
        end
    endtask

    // One command as a card would answer it: busy polls, frame, response polls, R1 and
    // extra bytes. Some end in a busy or response timeout, some are cut short.
    task automatic command_sequence(output int sent);
        int    outcome;
        int    budget;
        int    n_busy;
        int    n_poll;
        int    resp_eff;
        bit    busy_to;
        bit    resp_to;
        t_item cmd;
        sent     = 0;
        resp_eff = (resp_lim_now == 0) ? 1 : resp_lim_now;
        outcome  = $urandom_range(0, 99);
        budget   = (outcome >= 80) ? $urandom_range(1, 6) : 1000;
        busy_to  = (outcome < 15) && (busy_lim_now <= 8);
        resp_to  = (outcome >= 15) && (outcome < 30) && (resp_eff <= 8);
        cmd = command_item(CMD_W'($urandom_range(0, 63)), $urandom,
                           $urandom_range(0, 1) ? 8'h00 : BYTE_W'($urandom_range(1, 255)),
                           EXTRA_W'($urandom_range(0, 4)), 1'($urandom_range(0, 1)));
        feed_item(cmd, budget, sent);
        n_busy = busy_to ? busy_lim_now + 1
                         : $urandom_range(0, (busy_lim_now < 3) ? busy_lim_now : 3);
        for (int k = 0; k < n_busy; k++) begin
            feed_item(card_byte(BYTE_W'($urandom_range(0, 254))), budget, sent);
        end
        if (!busy_to) begin
            feed_item(card_byte(BYTE_IDLE), budget, sent);
            n_poll = resp_to ? resp_eff
                             : $urandom_range(0, (resp_eff - 1 < 3) ? resp_eff - 1 : 3);
            for (int k = 0; k < n_poll; k++) begin
                feed_item(card_byte(BYTE_W'($urandom_range(128, 255))), budget, sent);
            end
            if (!resp_to) begin
                feed_item(card_byte(BYTE_W'($urandom_range(0, 127))), budget, sent);
                for (int k = 0; k < cmd.extra; k++) begin
                    feed_item(card_byte(BYTE_W'($urandom_range(0, 255))), budget, sent);
                end
            end
        end
        // A broken sequence is sometimes tidied up by a release.
        if (outcome >= 80 && $urandom_range(0, 1)) begin
            send_request(filler(REQ_REL));
            sent++;
        end
    endtask

    // Mostly command sequences, with stray bytes, releases and unused request types.
    task automatic run_random_traffic(input int target);
        int done;
        int got;
        done = 0;
        while (done < target) begin
            if ($urandom_range(0, 99) < 15) begin
                case ($urandom_range(0, 2))
                    0:       send_request(card_byte(BYTE_W'($urandom_range(0, 255))));
                    1:       send_request(filler(REQ_REL));
                    default: send_request(filler(REQ_NONE));
                endcase
            end else begin
                command_sequence(got);
                done += got;
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Requests that do nothing while idle with chip select high.
        send_request(card_byte(8'h00));
        send_request(filler(REQ_REL));
        send_request(filler(REQ_NONE));
        // CMD0 with computed checksum, one busy poll, one response poll, then release.
        send_request(command_item(6'd0, 32'h0000_0000, 8'h00, 3'd0, 1'b1));
        send_request(card_byte(8'h00));
        send_request(card_byte(8'hFF));
        send_request(card_byte(8'hFF));
        send_request(card_byte(8'h01));
        // Highest command, all-ones argument, given checksum, four extra bytes, keep CS.
        send_request(command_item(6'd63, 32'hFFFF_FFFF, 8'hFF, 3'd4, 1'b0));
        send_request(card_byte(8'hFF));
        send_request(card_byte(8'h00));
        send_request(card_byte(8'hFF));
        send_request(card_byte(8'h00));
        send_request(card_byte(8'hA5));
        send_request(card_byte(8'h5A));
        // Release while chip select is still asserted.
        send_request(filler(REQ_REL));
        // A new command aborts one still polling for the card.
        send_request(command_item(6'd17, 32'h1234_5678, 8'h00, 3'd1, 1'b1));
        send_request(card_byte(8'h3C));
        send_request(command_item(6'd55, 32'h0000_0000, 8'h65, 3'd0, 1'b0));
        send_request(card_byte(8'hFF));
        send_request(card_byte(8'h7F));
        wait_for_drain();

        // Smallest limits: both timeouts first, then random traffic.
        write_config(CFG_BUSY, LIMIT_W'(1));
        write_config(CFG_RESP, LIMIT_W'(1));
        send_request(command_item(6'd8, 32'h0000_01AA, 8'h00, 3'd4, 1'b0));
        send_request(card_byte(8'h00));
        send_request(card_byte(8'hFE));
        send_request(command_item(6'd58, 32'h8000_0000, 8'h00, 3'd4, 1'b0));
        send_request(card_byte(8'hFF));
        send_request(card_byte(8'h80));
        run_random_traffic(15);
        wait_for_drain();

        // Largest limits, with a pause half way for every result to come back.
        write_config(CFG_BUSY, LIMIT_MAX);
        write_config(CFG_RESP, LIMIT_MAX);
        run_random_traffic(10);
        wait_for_drain();
        run_random_traffic(10);
        wait_for_drain();

        // A zero response limit behaves as one.
        write_config(CFG_BUSY, LIMIT_W'($urandom_range(2, 6)));
        write_config(CFG_RESP, '0);
        run_random_traffic(15);
        wait_for_drain();

        // Small random limits so that both timeouts come up now and then.
        write_config(CFG_RESP, LIMIT_W'($urandom_range(1, 8)));
        write_config(CFG_BUSY, LIMIT_W'($urandom_range(1, 8)));
        run_random_traffic(20);
        wait_for_drain();

        if (failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
